[rtl/core/rtac_pkg.sv]
package rtac_pkg;

   localparam int RelaysDefault   = 2;
   localparam int RelaysShown     = 2;
   localparam int NumberWidth     = 8;
   localparam int DelayWidth      = 20;
   localparam int TimeWidth       = 32;
   localparam int KindWidth       = 2;
   localparam int CsrAddrWidth    = 3;
   localparam int CsrDataWidth    = 32;
   localparam int ReqDataWidth    = 64;
   localparam int RspDataWidth    = 8;

   localparam logic [DelayWidth-1:0] MaxDelayReset = DelayWidth'(300000);

   // Register index as seen on csr_paddr[2]
   localparam logic RegMaxDelay = 1'b0;

   typedef enum logic [KindWidth-1:0] {
      KindToggle  = 2'd0,
      KindContact = 2'd1,
      KindTick    = 2'd2
   } kind_type;

   // Command broadcast from the top level to every relay lane
   typedef struct packed {
      logic                   apply;
      logic                   toggle_ok;
      logic                   contact_ok;
      logic                   tick;
      logic [NumberWidth-1:0] relay_number;
      logic [DelayWidth-1:0]  pulse_ms;
      logic [TimeWidth-1:0]   now_ms;
   } lane_cmd_type;

   // Status returned by each relay lane
   typedef struct packed {
      logic on_next;
      logic switched_off;
   } lane_status_type;

endpackage

[rtl/core/relay_toggle_and_timed_contact_core.sv]
// Channel | Role          | Handshake              | Payload
// req     | command/tick  | req_tvalid/req_tready  | tuser: kind; tdata: number, pulse, now
// rsp     | result        | rsp_tvalid/rsp_tready  | tdata: accepted, changed, relay_states
// csr     | configuration | APB, csr_pready tied 1 | max_delay_ms at byte address 0
//
// One word per cycle sustained while the result side is not stalled; each word is
// registered in the input register (held longer while the result register is stalled) and then sits
// in the result register until taken. The add and compare of the deadline
// check in each relay lane set the cycle.
// Synchronous active-high reset clears relay state, both valid flags and
// loads max_delay_ms with 300000. A stalled result holds; the input register
// still takes a word as long as it can hand its own word to the result side.
module relay_toggle_and_timed_contact_core #(
   parameter int RELAYS = rtac_pkg::RelaysDefault
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Input stream
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [7:0] relay_number, [27:8] pulse_ms, [59:28] now_ms, [63:60] zero
   input  logic [rtac_pkg::ReqDataWidth-1:0]     req_tdata,
   // [1:0] kind
   input  logic [rtac_pkg::KindWidth-1:0]        req_tuser,
   // Result stream
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [0] accepted, [1] changed, [3:2] relay_states, [7:4] zero
   output logic [rtac_pkg::RspDataWidth-1:0]     rsp_tdata,
   // Configuration
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [rtac_pkg::CsrAddrWidth-1:0]     csr_paddr,
   input  logic [rtac_pkg::CsrDataWidth-1:0]     csr_pwdata,
   output logic [rtac_pkg::CsrDataWidth-1:0]     csr_prdata,
   output logic                                  csr_pready
);

   localparam int Shown = (RELAYS < rtac_pkg::RelaysShown) ? RELAYS : rtac_pkg::RelaysShown;

   logic [rtac_pkg::DelayWidth-1:0] max_delay_ms;

   // Input register
   logic                             in_valid_ff;
   logic                             in_valid_in;
   rtac_pkg::kind_type               kind_ff;
   logic [rtac_pkg::NumberWidth-1:0] number_ff;
   logic [rtac_pkg::DelayWidth-1:0]  delay_ff;
   logic [rtac_pkg::TimeWidth-1:0]   now_ff;

   // Result register
   logic                             out_valid_ff;
   logic                             out_valid_in;
   logic                             accepted_ff;
   logic                             changed_ff;
   logic [rtac_pkg::RelaysShown-1:0] states_ff;

   logic                             advance;
   logic                             req_take;
   logic                             number_ok;
   logic                             accepted;
   rtac_pkg::lane_cmd_type           cmd;
   rtac_pkg::lane_status_type        status [RELAYS];
   logic [RELAYS-1:0]                off_bits;
   logic [rtac_pkg::RelaysShown-1:0] states_next;

   assign csr_pready = 1'b1;

   rtac_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .max_delay_ms (max_delay_ms)
   );

   // Advance the held word when the result register is free or being drained
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         kind_ff   <= rtac_pkg::kind_type'(req_tuser);
         number_ff <= req_tdata[7:0];
         delay_ff  <= req_tdata[27:8];
         now_ff    <= req_tdata[59:28];
      end
   end

   // Decode the held word once, then broadcast it to the lanes
   assign number_ok = (number_ff != '0) &&
                      (number_ff <= rtac_pkg::NumberWidth'(RELAYS));

   always_comb begin
      cmd              = '0;
      cmd.apply        = advance;
      cmd.relay_number = number_ff;
      cmd.pulse_ms     = delay_ff;
      cmd.now_ms       = now_ff;
      accepted         = 1'b0;
      case (kind_ff)
         rtac_pkg::KindToggle: begin
            cmd.toggle_ok = number_ok;
            accepted      = number_ok;
         end
         rtac_pkg::KindContact: begin
            cmd.contact_ok = number_ok && (delay_ff != '0) && (delay_ff <= max_delay_ms);
            accepted       = cmd.contact_ok;
         end
         rtac_pkg::KindTick: begin
            cmd.tick = 1'b1;
            accepted = 1'b1;
         end
         default: begin
            accepted = 1'b0;
         end
      endcase
   end

   for (genvar g = 0; g < RELAYS; g++) begin : g_lane
      rtac_lane #(
         .LANE_INDEX (g)
      ) u_lane (
         .clock  (clock),
         .reset  (reset),
         .cmd    (cmd),
         .status (status[g])
      );
      assign off_bits[g] = status[g].switched_off;
   end

   // Only the first relays show up in the result word
   always_comb begin
      states_next = '0;
      for (int i = 0; i < Shown; i++) begin
         states_next[i] = status[i].on_next;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         accepted_ff <= accepted;
         changed_ff  <= |off_bits;
         states_ff   <= states_next;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, states_ff, changed_ff, accepted_ff};

endmodule

[rtl/core/rtac_csr.sv]
module rtac_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [rtac_pkg::CsrAddrWidth-1:0]     csr_paddr,
   input  logic [rtac_pkg::CsrDataWidth-1:0]     csr_pwdata,
   output logic [rtac_pkg::CsrDataWidth-1:0]     csr_prdata,
   output logic [rtac_pkg::DelayWidth-1:0]       max_delay_ms
);

   logic [rtac_pkg::DelayWidth-1:0] max_delay_ff;
   logic [rtac_pkg::DelayWidth-1:0] max_delay_in;
   logic                            reg_sel;

   assign reg_sel = (csr_paddr[2] == rtac_pkg::RegMaxDelay);

   always_comb begin
      max_delay_in = max_delay_ff;
      if (csr_psel && csr_penable && csr_pwrite && reg_sel) begin
         max_delay_in = csr_pwdata[rtac_pkg::DelayWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_delay_ff <= rtac_pkg::MaxDelayReset;
      end else begin
         max_delay_ff <= max_delay_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (reg_sel) begin
         csr_prdata = rtac_pkg::CsrDataWidth'(max_delay_ff);
      end
   end

   assign max_delay_ms = max_delay_ff;

endmodule

[rtl/core/rtac_lane.sv]
module rtac_lane #(
   parameter int LANE_INDEX = 0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  rtac_pkg::lane_cmd_type    cmd,
   output rtac_pkg::lane_status_type status
);

   logic                            on_ff;
   logic                            on_in;
   logic [rtac_pkg::DelayWidth-1:0] pend_ff;
   logic [rtac_pkg::DelayWidth-1:0] pend_in;
   logic [rtac_pkg::TimeWidth-1:0]  deadline_ff;
   logic [rtac_pkg::TimeWidth-1:0]  deadline_in;
   logic [rtac_pkg::TimeWidth-1:0]  armed_deadline;
   logic                            hit;
   logic                            expire;

   assign hit = (cmd.relay_number == rtac_pkg::NumberWidth'(LANE_INDEX + 1));

   // A pending length becomes a deadline on the tick, then gets checked at once
   always_comb begin
      armed_deadline = deadline_ff;
      if (pend_ff != '0) begin
         armed_deadline = cmd.now_ms + rtac_pkg::TimeWidth'(pend_ff);
      end
   end

   assign expire = (armed_deadline != '0) && (cmd.now_ms >= armed_deadline);

   always_comb begin
      on_in       = on_ff;
      pend_in     = pend_ff;
      deadline_in = deadline_ff;
      if (cmd.tick) begin
         pend_in     = '0;
         deadline_in = expire ? '0 : armed_deadline;
         on_in       = expire ? 1'b0 : on_ff;
      end else if (cmd.toggle_ok && hit) begin
         pend_in     = '0;
         deadline_in = '0;
         on_in       = !on_ff;
      end else if (cmd.contact_ok && hit) begin
         pend_in     = cmd.pulse_ms;
         deadline_in = '0;
         on_in       = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         on_ff       <= 1'b0;
         pend_ff     <= '0;
         deadline_ff <= '0;
      end else if (cmd.apply) begin
         on_ff       <= on_in;
         pend_ff     <= pend_in;
         deadline_ff <= deadline_in;
      end
   end

   assign status.on_next      = on_in;
   assign status.switched_off = cmd.tick && expire && on_ff;

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps

module testbench;

   localparam int NumRelays = rtac_pkg::RelaysDefault;
   // The fourth kind code has no meaning; the block must reject it.
   localparam logic [rtac_pkg::KindWidth-1:0] KindUnused = 2'd3;
   localparam logic [rtac_pkg::CsrAddrWidth-1:0] MaxDelayAddr =
      rtac_pkg::CsrAddrWidth'({rtac_pkg::RegMaxDelay, 2'b00});
   localparam int LongStall = 40;

   // One command or tick as the sender sees it
   typedef struct packed {
      logic [rtac_pkg::KindWidth-1:0]   kind;
      logic [rtac_pkg::NumberWidth-1:0] relay_number;
      logic [rtac_pkg::DelayWidth-1:0]  pulse_ms;
      logic [rtac_pkg::TimeWidth-1:0]   now_ms;
   } relay_word_type;

   // Same bit order as rsp_tdata[3:0]
   typedef struct packed {
      logic [1:0] relay_states;
      logic       changed;
      logic       accepted;
   } relay_result_type;

   logic clock;
   logic reset = 1'b1;

   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [rtac_pkg::ReqDataWidth-1:0] req_tdata = '0;
   logic [rtac_pkg::KindWidth-1:0]    req_tuser = '0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [rtac_pkg::RspDataWidth-1:0] rsp_tdata;
   logic                              csr_psel = 1'b0;
   logic                              csr_penable = 1'b0;
   logic                              csr_pwrite = 1'b0;
   logic [rtac_pkg::CsrAddrWidth-1:0] csr_paddr = '0;
   logic [rtac_pkg::CsrDataWidth-1:0] csr_pwdata = '0;
   logic [rtac_pkg::CsrDataWidth-1:0] csr_prdata;
   logic                              csr_pready;

   relay_toggle_and_timed_contact_core #(
      .RELAYS (NumRelays)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Shadow of the relay bank, advanced once per accepted word
   logic                            model_on       [NumRelays];
   logic [rtac_pkg::DelayWidth-1:0] model_pending  [NumRelays];
   logic [rtac_pkg::TimeWidth-1:0]  model_deadline [NumRelays];
   logic [rtac_pkg::DelayWidth-1:0] model_max_delay = rtac_pkg::MaxDelayReset;

   relay_word_type   pending_words[$];
   relay_result_type expected_results[$];
   relay_word_type   on_bus;

   int error_count = 0;
   int results_seen = 0;
   int gap_left = 0;
   int stall_left = 0;
   logic long_stall_done = 1'b0;
   logic long_hold = 1'b0;
   logic quiet_tail = 1'b0;
   // Running millisecond time used to build ticks that actually hit deadlines
   logic [rtac_pkg::TimeWidth-1:0] tick_cursor = '0;

   initial begin
      for (int i = 0; i < NumRelays; i++) begin
         model_on[i] = 1'b0;
         model_pending[i] = '0;
         model_deadline[i] = '0;
      end
   end

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      error_count++;
   endtask

   // Apply one word to the shadow bank and return the result it must produce.
   function automatic relay_result_type advance_relays(input relay_word_type w);
      relay_result_type r;
      logic num_ok;
      int idx;
      r = '0;
      num_ok = (w.relay_number >= 1) && (w.relay_number <= NumRelays);
      idx = int'(w.relay_number) - 1;
      case (w.kind)
         rtac_pkg::KindToggle: begin
            if (num_ok) begin
               model_pending[idx] = '0;
               model_deadline[idx] = '0;
               model_on[idx] = ~model_on[idx];
               r.accepted = 1'b1;
            end
         end
         rtac_pkg::KindContact: begin
            if (num_ok && w.pulse_ms != '0 && w.pulse_ms <= model_max_delay) begin
               model_on[idx] = 1'b1;
               model_pending[idx] = w.pulse_ms;
               model_deadline[idx] = '0;
               r.accepted = 1'b1;
            end
         end
         rtac_pkg::KindTick: begin
            r.accepted = 1'b1;
            for (int i = 0; i < NumRelays; i++) begin
               // arm first, then compare; a sum that wraps small fires at once
               if (model_pending[i] != '0) begin
                  model_deadline[i] = w.now_ms + rtac_pkg::TimeWidth'(model_pending[i]);
                  model_pending[i] = '0;
               end
               if (model_deadline[i] != '0 && w.now_ms >= model_deadline[i]) begin
                  model_deadline[i] = '0;
                  model_on[i] = 1'b0;
                  r.changed = 1'b1;
               end
            end
         end
         default: ;
      endcase
      for (int i = 0; i < NumRelays && i < rtac_pkg::RelaysShown; i++)
         r.relay_states[i] = model_on[i];
      return r;
   endfunction

   function automatic relay_word_type make_word(input logic [rtac_pkg::KindWidth-1:0] kind,
                                                input int num, input int delay,
                                                input logic [rtac_pkg::TimeWidth-1:0] now);
      relay_word_type w;
      w.kind = kind;
      w.relay_number = rtac_pkg::NumberWidth'(num);
      w.pulse_ms = rtac_pkg::DelayWidth'(delay);
      w.now_ms = now;
      return w;
   endfunction

   // Mostly well-formed traffic around the running time, with some noise.
   function automatic relay_word_type random_word();
      relay_word_type w;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
         w.kind = rtac_pkg::KindWidth'($urandom_range(0, 3));
         w.relay_number = rtac_pkg::NumberWidth'($urandom);
         w.pulse_ms = rtac_pkg::DelayWidth'($urandom);
         w.now_ms = $urandom;
         return w;
      end
      pick = $urandom_range(0, 99);
      if (pick < 22)      w.kind = rtac_pkg::KindToggle;
      else if (pick < 57) w.kind = rtac_pkg::KindContact;
      else if (pick < 97) w.kind = rtac_pkg::KindTick;
      else                w.kind = KindUnused;

      if ($urandom_range(0, 9) != 0)
         w.relay_number = rtac_pkg::NumberWidth'($urandom_range(1, NumRelays));
      else if ($urandom_range(0, 1) == 0)
         w.relay_number = '0;
      else
         w.relay_number = rtac_pkg::NumberWidth'($urandom_range(NumRelays + 1, 255));

      pick = $urandom_range(0, 99);
      if (model_max_delay != '0 && pick < 80)
         w.pulse_ms = rtac_pkg::DelayWidth'($urandom_range(1, int'(model_max_delay)));
      else if (pick < 85)
         w.pulse_ms = model_max_delay;
      else if (pick < 90)
         w.pulse_ms = model_max_delay + 1'b1;
      else if (pick < 95)
         w.pulse_ms = '0;
      else
         w.pulse_ms = rtac_pkg::DelayWidth'($urandom);

      if (w.kind == rtac_pkg::KindTick) begin
         pick = $urandom_range(0, 99);
         if (pick < 4)
            tick_cursor = $urandom;
         else if (pick < 7)
            tick_cursor = '1 -
                          rtac_pkg::TimeWidth'($urandom_range(0, int'(model_max_delay)));
         else
            tick_cursor = tick_cursor +
               rtac_pkg::TimeWidth'($urandom_range(0, int'(model_max_delay) / 2 + 2));
         w.now_ms = tick_cursor;
      end else begin
         w.now_ms = $urandom;
      end
      return w;
   endfunction

   // Hold until the sender is empty and every expected result has been taken.
   // Look just after the edge so the driver and monitor updates have landed.
   task automatic wait_drained();
      do begin
         @(posedge clock);
         #1;
      end while (pending_words.size() != 0 || req_tvalid || expected_results.size() != 0);
   endtask

   // Two-phase register write; only called while the block is idle.
   task automatic write_max_delay(input logic [rtac_pkg::DelayWidth-1:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= MaxDelayAddr;
      csr_pwdata <= rtac_pkg::CsrDataWidth'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      model_max_delay = value;
   endtask

   task automatic run_random(input int count);
      for (int n = 0; n < count; n++)
         pending_words.push_back(random_word());
      wait_drained();
   endtask

   // Driver: one word on the bus at a time, valid held until taken.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            expected_results.push_back(advance_relays(on_bus));
         // change the bus only when nothing is waiting on it
         if (!(req_tvalid && !req_tready)) begin
            if (gap_left > 0) begin
               gap_left = gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
               gap_left = $urandom_range(0, 2);
               req_tvalid <= 1'b0;
            end else if (pending_words.size() != 0) begin
               on_bus = pending_words.pop_front();
               req_tdata <= {4'b0, on_bus.now_ms, on_bus.pulse_ms, on_bus.relay_number};
               req_tuser <= on_bus.kind;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // One long hold-off mid-run so the block backs up into its input
   always @(posedge clock) begin
      if (!reset && !long_stall_done && results_seen >= 300) begin
         long_stall_done = 1'b1;
         long_hold = 1'b1;
         repeat (LongStall) @(posedge clock);
         long_hold = 1'b0;
      end
   end

   // Monitor: check each taken result against the oldest expectation.
   always @(posedge clock) begin
      relay_result_type got;
      relay_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = relay_result_type'(rsp_tdata[3:0]);
            results_seen++;
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("unexpected result word %h", rsp_tdata));
            end else begin
               want = expected_results.pop_front();
               if (got.accepted !== want.accepted)
                  report_mismatch($sformatf("accepted %b, want %b", got.accepted,
                                            want.accepted));
               if (got.changed !== want.changed)
                  report_mismatch($sformatf("changed %b, want %b", got.changed,
                                            want.changed));
               if (got.relay_states !== want.relay_states)
                  report_mismatch($sformatf("relay_states %b, want %b", got.relay_states,
                                            want.relay_states));
            end
         end
         if (stall_left == 0 && !quiet_tail && $urandom_range(0, 4) == 0)
            stall_left = $urandom_range(1, 3);
         if (long_hold) begin
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Sequencer: reset, directed words, then random phases over several limits.
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part at the reset limit of 300000
      pending_words.push_back(make_word(rtac_pkg::KindTick, 0, 0, 32'h0));
      pending_words.push_back(make_word(rtac_pkg::KindToggle, 1, 0, 32'h0));
      pending_words.push_back(make_word(rtac_pkg::KindToggle, 2, 1048575, 32'hFFFF_FFFF));
      pending_words.push_back(make_word(rtac_pkg::KindToggle, 2, 0, 32'h0));
      // bad relay numbers
      pending_words.push_back(make_word(rtac_pkg::KindToggle, 0, 0, 32'h0));
      pending_words.push_back(make_word(rtac_pkg::KindToggle, NumRelays + 1, 0, 32'h0));
      pending_words.push_back(make_word(rtac_pkg::KindToggle, 255, 0, 32'h0));
      // unused kind
      pending_words.push_back(make_word(KindUnused, 1, 5, 32'h0));
      // bad lengths and a bad relay number, then the limit itself
      pending_words.push_back(make_word(rtac_pkg::KindContact, 1, 0, 32'h0));
      pending_words.push_back(make_word(rtac_pkg::KindContact, 1, 300001, 32'h0));
      pending_words.push_back(make_word(rtac_pkg::KindContact, 1, 1048575, 32'h0));
      pending_words.push_back(make_word(rtac_pkg::KindContact, 255, 5, 32'h0));
      pending_words.push_back(make_word(rtac_pkg::KindContact, 1, 300000, 32'h0));
      pending_words.push_back(make_word(rtac_pkg::KindContact, 2, 1, 32'h0));
      // arm both, then reach each deadline in turn
      pending_words.push_back(make_word(rtac_pkg::KindTick, 0, 0, 32'd100));
      pending_words.push_back(make_word(rtac_pkg::KindTick, 0, 0, 32'd101));
      pending_words.push_back(make_word(rtac_pkg::KindTick, 0, 0, 32'd300100));
      // sum wraps to exactly zero: no deadline, relay stays on
      pending_words.push_back(make_word(rtac_pkg::KindContact, 1, 16, 32'h0));
      pending_words.push_back(make_word(rtac_pkg::KindTick, 0, 0, 32'hFFFF_FFF0));
      // sum wraps past zero: fires on the same tick
      pending_words.push_back(make_word(rtac_pkg::KindContact, 2, 100, 32'h0));
      pending_words.push_back(make_word(rtac_pkg::KindTick, 0, 0, 32'hFFFF_FFF0));
      // toggle cancels a pending pulse
      pending_words.push_back(make_word(rtac_pkg::KindContact, 1, 5, 32'h0));
      pending_words.push_back(make_word(rtac_pkg::KindToggle, 1, 0, 32'h0));
      pending_words.push_back(make_word(rtac_pkg::KindTick, 0, 0, 32'd1000));
      pending_words.push_back(make_word(rtac_pkg::KindTick, 0, 0, 32'hFFFF_FFFF));
      wait_drained();

      run_random(400);
      write_max_delay(rtac_pkg::DelayWidth'(1));
      run_random(200);
      write_max_delay('1);
      run_random(400);
      // a zero limit rejects every contact
      write_max_delay('0);
      run_random(100);
      write_max_delay(rtac_pkg::DelayWidth'($urandom_range(1, 1048575)));
      run_random(300);
      write_max_delay(rtac_pkg::DelayWidth'($urandom_range(16, 4096)));
      quiet_tail = 1'b1;
      run_random(350);

      // let any stray word surface before the verdict
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

   initial begin
      #2000000;
      $display("testbench: errors");
      $finish;
   end

endmodule
